// ===== rtl/dsg_pkg.sv =====
package dsg_pkg;

  localparam int DEF_ACC_WIDTH   = 32;
  localparam int DEF_JOINT_COUNT = 8;

  localparam int QUEUE_DEPTH  = 4;
  localparam int RESULT_DEPTH = 2;

  localparam logic [2:0]  RESET_JOINT_INDEX     = 3'd0;
  localparam logic [4:0]  RESET_STEP_BIT        = 5'd22;
  localparam logic [31:0] RESET_FREQUENCY_SCALE = 32'd0;

  localparam logic [31:0] INC_MAX_POS = 32'h7fff_ffff;
  localparam logic [31:0] INC_MAX_NEG = 32'h8000_0000;

  typedef enum logic [1:0] {
    REG_JOINT_INDEX,
    REG_STEP_BIT,
    REG_FREQUENCY_SCALE
  } cfg_reg_t;

  typedef struct packed {
    logic               enabled;
    logic               forward;
    logic signed [31:0] increment;
  } tick_t;

  typedef struct packed {
    logic               step_out;
    logic               direction_out;
    logic               driver_enable_n;
    logic signed [31:0] position_feedback;
    logic               feedback_updated;
  } result_t;

  localparam int TICK_W   = $bits(tick_t);
  localparam int RESULT_W = $bits(result_t);

endpackage

// ===== rtl/dsg_fifo.sv =====
module dsg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;

  logic do_push;
  logic do_pop;

  assign empty   = (count == '0);
  assign full    = (count == (AW+1)'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/dsg_front.sv =====
module dsg_front #(
  parameter int JOINT_COUNT = dsg_pkg::DEF_JOINT_COUNT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [31:0]  frequency_command,
  input  logic [7:0]          enable_bits,
  input  logic [2:0]          joint_index,
  input  logic [31:0]         frequency_scale,
  output logic                out_valid,
  output dsg_pkg::tick_t      out_item,
  output logic [1:0]          inflight
);

  logic        in_enabled;
  logic        in_neg;
  logic [31:0] in_mag;
  logic [63:0] in_prod;

  logic        s1_valid;
  logic        s1_enabled;
  logic        s1_neg;
  logic [47:0] s1_prod;

  logic [31:0] pos_inc;
  logic [31:0] neg_mag;
  dsg_pkg::tick_t s2_item_next;

  logic           s2_valid;
  dsg_pkg::tick_t s2_item;

  assign in_enabled = (int'(joint_index) < JOINT_COUNT) && enable_bits[joint_index];
  assign in_neg     = frequency_command[31];
  assign in_mag     = in_neg ? (~frequency_command + 32'd1) : frequency_command;
  assign in_prod    = in_mag * frequency_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s1_enabled <= in_enabled;
      s1_neg     <= in_neg;
      s1_prod    <= in_prod[63:16];
    end
  end

  // saturate magnitude, then restore sign
  always_comb begin
    pos_inc = (|s1_prod[47:31]) ? dsg_pkg::INC_MAX_POS : s1_prod[31:0];
    neg_mag = ((|s1_prod[47:32]) || (s1_prod[31] && (|s1_prod[30:0])))
              ? dsg_pkg::INC_MAX_NEG : s1_prod[31:0];
    s2_item_next.enabled   = s1_enabled;
    s2_item_next.forward   = !s1_neg && (|s1_prod);
    s2_item_next.increment = s1_neg ? (~neg_mag + 32'd1) : pos_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_item <= s2_item_next;
    end
  end

  assign out_valid = s2_valid;
  assign out_item  = s2_item;
  assign inflight  = {1'b0, s1_valid} + {1'b0, s2_valid};

endmodule

// ===== rtl/dsg_back.sv =====
module dsg_back #(
  parameter int ACC_WIDTH = dsg_pkg::DEF_ACC_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  dsg_pkg::tick_t   item,
  input  logic             res_full,
  input  logic [4:0]       step_bit,
  output logic             item_pop,
  output logic             res_push,
  output dsg_pkg::result_t res
);

  logic [ACC_WIDTH-1:0] acc;
  logic [ACC_WIDTH-1:0] acc_next;
  logic                 step_level;
  logic                 step_level_next;
  logic                 dir_level;
  logic                 dir_level_next;
  logic                 enable_level;
  logic                 enable_level_next;
  logic signed [31:0]   feedback_hold;
  logic signed [31:0]   feedback_hold_next;

  logic [ACC_WIDTH-1:0] acc_sum;
  logic [ACC_WIDTH-1:0] toggled;
  logic                 stepped;

  assign item_pop = item_valid && !res_full;
  assign res_push = item_pop;

  assign acc_sum = acc + ACC_WIDTH'($signed(item.increment));
  assign toggled = (acc ^ acc_sum) >> step_bit;
  assign stepped = item.enabled && toggled[0];

  always_comb begin
    acc_next           = acc;
    step_level_next    = step_level;
    dir_level_next     = dir_level;
    enable_level_next  = 1'b1;
    feedback_hold_next = feedback_hold;
    if (item.enabled) begin
      acc_next          = acc_sum;
      enable_level_next = 1'b0;
      step_level_next   = stepped;
      if (stepped) begin
        dir_level_next     = item.forward;
        feedback_hold_next = 32'($signed(acc_sum));
      end
    end
    res.step_out          = step_level_next;
    res.direction_out     = dir_level_next;
    res.driver_enable_n   = enable_level_next;
    res.position_feedback = feedback_hold_next;
    res.feedback_updated  = stepped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      step_level    <= 1'b0;
      dir_level     <= 1'b0;
      enable_level  <= 1'b1;
      feedback_hold <= '0;
    end else if (item_pop) begin
      acc           <= acc_next;
      step_level    <= step_level_next;
      dir_level     <= dir_level_next;
      enable_level  <= enable_level_next;
      feedback_hold <= feedback_hold_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_disabled_holds_acc: assert property (@(posedge clk) disable iff (rst)
    (item_pop && !item.enabled) |=> $stable(acc))
    else $error("accumulator moved on a disabled tick");

  a_disabled_drives_high: assert property (@(posedge clk) disable iff (rst)
    (item_pop && !item.enabled) |=> (enable_level && $stable(feedback_hold)))
    else $error("disabled tick did not release driver or hold feedback");
`endif

endmodule

// ===== rtl/dds_step_pulse_generator.sv =====
// Channel   Handshake              Payload
// input     push / full            frequency_command, enable_bits
// result    empty / pop            step_out, direction_out, driver_enable_n,
//                                  position_feedback, feedback_updated
// config    cfg_write              cfg_index, cfg_data
//
// One tick is taken per cycle while full is low; throughput is set by the single accumulator add in the back end.
// After the transfer a tick passes the multiply stage, the saturate stage and the tick queue,
// then the accumulator update writes the result queue, whose head drives the ports.
// Synchronous reset empties both queues and restores the register defaults.
// A stalled result side fills the result queue, then the tick queue, then full rises.
module dds_step_pulse_generator #(
  parameter int ACC_WIDTH   = dsg_pkg::DEF_ACC_WIDTH,
  parameter int JOINT_COUNT = dsg_pkg::DEF_JOINT_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] frequency_command,
  input  logic [7:0]         enable_bits,
  output logic               empty,
  input  logic               pop,
  output logic               step_out,
  output logic               direction_out,
  output logic               driver_enable_n,
  output logic signed [31:0] position_feedback,
  output logic               feedback_updated,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int QCW = $clog2(dsg_pkg::QUEUE_DEPTH) + 1;
  localparam int RCW = $clog2(dsg_pkg::RESULT_DEPTH) + 1;

  logic [2:0]  joint_index;
  logic [4:0]  step_bit;
  logic [31:0] frequency_scale;

  logic           accept;
  logic           mid_push;
  dsg_pkg::tick_t mid_witem;
  logic [dsg_pkg::TICK_W-1:0] mid_rdata;
  logic           mid_pop;
  logic           mid_empty;
  logic           mid_full;
  logic [QCW-1:0] mid_count;
  logic [1:0]     inflight;
  logic [QCW:0]   pending;

  logic             out_push;
  dsg_pkg::result_t out_wres;
  logic [dsg_pkg::RESULT_W-1:0] out_rdata;
  dsg_pkg::result_t out_res;
  logic             out_full;
  logic [RCW-1:0]   out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      joint_index     <= dsg_pkg::RESET_JOINT_INDEX;
      step_bit        <= dsg_pkg::RESET_STEP_BIT;
      frequency_scale <= dsg_pkg::RESET_FREQUENCY_SCALE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dsg_pkg::REG_JOINT_INDEX:     joint_index     <= cfg_data[2:0];
        dsg_pkg::REG_STEP_BIT:        step_bit        <= cfg_data[4:0];
        dsg_pkg::REG_FREQUENCY_SCALE: frequency_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // reserve tick queue space for every tick still in the front stages
  assign pending = (QCW+1)'(mid_count) + (QCW+1)'(inflight);
  assign full    = (pending >= (QCW+1)'(dsg_pkg::QUEUE_DEPTH));
  assign accept  = push && !full;

  dsg_front #(
    .JOINT_COUNT (JOINT_COUNT)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (accept),
    .frequency_command (frequency_command),
    .enable_bits       (enable_bits),
    .joint_index       (joint_index),
    .frequency_scale   (frequency_scale),
    .out_valid         (mid_push),
    .out_item          (mid_witem),
    .inflight          (inflight)
  );

  dsg_fifo #(
    .WIDTH (dsg_pkg::TICK_W),
    .DEPTH (dsg_pkg::QUEUE_DEPTH)
  ) u_tick_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_witem),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .full  (mid_full),
    .count (mid_count)
  );

  dsg_back #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (!mid_empty),
    .item       (dsg_pkg::tick_t'(mid_rdata)),
    .res_full   (out_full),
    .step_bit   (step_bit),
    .item_pop   (mid_pop),
    .res_push   (out_push),
    .res        (out_wres)
  );

  dsg_fifo #(
    .WIDTH (dsg_pkg::RESULT_W),
    .DEPTH (dsg_pkg::RESULT_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wres),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty),
    .full  (out_full),
    .count (out_count)
  );

  assign out_res           = dsg_pkg::result_t'(out_rdata);
  assign step_out          = out_res.step_out;
  assign direction_out     = out_res.direction_out;
  assign driver_enable_n   = out_res.driver_enable_n;
  assign position_feedback = out_res.position_feedback;
  assign feedback_updated  = out_res.feedback_updated;

`ifndef NO_ASSERTIONS
  a_tick_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(mid_push && mid_full))
    else $error("tick queue overflow");

  a_result_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(out_push && out_full) && (out_count <= RCW'(dsg_pkg::RESULT_DEPTH)))
    else $error("result queue overflow");

  a_update_implies_step: assert property (@(posedge clk) disable iff (rst)
    (!empty && feedback_updated) |-> (step_out && !driver_enable_n))
    else $error("feedback captured without a step");
`endif

endmodule
